>>> rtl/bpfa_pkg.sv
// ----------------------------------------------------------------------------
// bpfa_pkg
// Shared types, constants and word helpers for the bitmap frame allocator.
// ----------------------------------------------------------------------------
package bpfa_pkg;

	localparam int MAP_WORDS = 1024;
	localparam int WORD_AW   = $clog2(MAP_WORDS);
	localparam int CNT_W     = WORD_AW + 1;
	localparam int FRAME_W   = 20;
	localparam int USED_W    = 16;
	localparam int FREE_W    = USED_W + 1;

	localparam logic [2:0] MODE_ALLOC1 = 3'd0;
	localparam logic [2:0] MODE_ALLOC8 = 3'd1;
	localparam logic [2:0] MODE_ALLOC32 = 3'd2;
	localparam logic [2:0] MODE_FREE1 = 3'd3;
	localparam logic [2:0] MODE_FREE8 = 3'd4;
	localparam logic [2:0] MODE_FREE32 = 3'd5;
	localparam logic [2:0] MODE_QUERY = 3'd6;

	localparam logic REG_ACTIVE_WORDS = 1'b0;
	localparam logic REG_BASE_FRAME   = 1'b1;

	localparam logic [31:0] WORD_FULL = 32'hFFFF_FFFF;
	localparam logic [CNT_W-1:0] ACTIVE_RESET = CNT_W'(MAP_WORDS);

	typedef struct packed {
		logic [2:0]         mode;
		logic [FRAME_W-1:0] frame;
	} req_t;

	typedef struct packed {
		logic [FRAME_W-1:0] result_frame;
		logic               ok;
		logic               is_allocated;
		logic [USED_W-1:0]  used_count;
	} rsp_t;

	typedef enum logic [3:0] {
		S_CLEAR,
		S_IDLE,
		S_SCAN,
		S_RUN_RD,
		S_RUN_LO,
		S_RUN_HI,
		S_RUN_WR2,
		S_FREE_CHK,
		S_FREE_HI,
		S_FREE_WR2,
		S_DONE
	} state_t;

	// index of the lowest clear bit; only meaningful for a word that is not full
	function automatic logic [4:0] lowest_zero(input logic [31:0] v);
		logic [4:0] b;
		b = 5'd0;
		for (int i = 31; i >= 0; i--) begin
			if (!v[i]) b = 5'(i);
		end
		return b;
	endfunction

	// {hit, byte index} of the first all-zero byte
	function automatic logic [2:0] first_zero_byte(input logic [31:0] v);
		logic [2:0] r;
		r = 3'b000;
		for (int k = 3; k >= 0; k--) begin
			if (v[8*k +: 8] == 8'h00) r = {1'b1, 2'(k)};
		end
		return r;
	endfunction

	function automatic logic [31:0] byte_mask(input logic [1:0] k);
		return 32'h0000_00FF << {k, 3'b000};
	endfunction

	// bits of the word from byte k upward; the rest of a run lies in the next word
	function automatic logic [31:0] lo_mask(input logic [1:0] k);
		return WORD_FULL << {k, 3'b000};
	endfunction

	function automatic logic [31:0] run_bits(input logic [31:0] lo, input logic [31:0] hi,
			input logic [1:0] k);
		logic [31:0] r;
		unique case (k)
			2'd0: r = lo;
			2'd1: r = {hi[7:0], lo[31:8]};
			2'd2: r = {hi[15:0], lo[31:16]};
			2'd3: r = {hi[23:0], lo[31:24]};
			default: r = lo;
		endcase
		return r;
	endfunction

endpackage

>>> rtl/bitmap_page_frame_allocator.sv
// ----------------------------------------------------------------------------
// bitmap_page_frame_allocator
// Next-fit bitmap allocator of page frames, one bit per frame.
// ----------------------------------------------------------------------------
// After reset the block sweeps the bitmap memory to zero, one word per cycle,
// and takes no request until that is done. Requests are then handled one at
// a time. Single-bit, byte and whole-word allocations read one bitmap word per
// cycle from the next-fit pointer, examining from one word up to the active
// word count. A 32-frame allocation that finds no free word, while at least 32
// frames are free, falls back to a run search that reads each candidate word
// and the next one through the single read port (the last active word is
// skipped as a candidate); a hit then writes the second word in its own state.
// Frees and queries read the addressed word, and a 32-frame free that straddles
// two words also reads and writes the next one.
// The result register frees the input side as soon as a result is loaded.
module bitmap_page_frame_allocator
	import bpfa_pkg::*;
(
	input  logic         clk,
	input  logic         arst_n,
	input  logic         cfg_we,
	input  logic         cfg_index,
	input  logic [19:0]  cfg_data,
	input  logic         in_valid,
	output logic         in_stall,
	input  req_t         in_data,
	output logic         out_valid,
	input  logic         out_stall,
	output rsp_t         out_data
);

	state_t state_q, state_d;

	logic [CNT_W-1:0]   aw_q, n_q, nc, cnt_q;
	logic [FRAME_W-1:0] base_q, res_q;
	logic [2:0]         mode_q;
	logic [WORD_AW-1:0] p_q, ptr_q, word_q, clr_q, start, p_nx;
	logic [4:0]         bit_q;
	logic [1:0]         k_q;
	logic [31:0]        lo_q, hi_q;
	logic [USED_W-1:0]  used_q;
	logic [FREE_W-1:0]  free_q, free_now;
	logic               ok_q, isal_q, out_valid_q;
	rsp_t               out_q;

	logic               wr_en, rd_en;
	logic [WORD_AW-1:0] wr_addr, rd_addr;
	logic [31:0]        wr_data, rdata;

	logic               acc, go_scan, go_free, in_rng, last, skip, scan_hit, run_hit;
	logic               free_ok, hi_good, done_go;
	logic [FRAME_W-1:0] rel;
	logic [CNT_W-1:0]   p_inc;
	logic [2:0]         zb;
	logic [1:0]         run_k;
	logic [2:0]         run_sel;

	bpfa_ram u_ram (
		.clk     (clk),
		.wr_en   (wr_en),
		.wr_addr (wr_addr),
		.wr_data (wr_data),
		.rd_en   (rd_en),
		.rd_addr (rd_addr),
		.rd_data (rdata)
	);

	// ---------------- shared decode ----------------
	always_comb begin
		if (aw_q == '0) nc = CNT_W'(1);
		else if (aw_q > CNT_W'(MAP_WORDS)) nc = CNT_W'(MAP_WORDS);
		else nc = aw_q;
		if ({1'b0, nc, 5'b00000} > FREE_W'(used_q))
			free_now = FREE_W'({nc, 5'b00000}) - FREE_W'(used_q);
		else
			free_now = '0;
		start = ({1'b0, ptr_q} >= nc) ? '0 : ptr_q;
		acc = (state_q == S_IDLE) && in_valid;
		rel = in_data.frame - base_q;
		in_rng = (in_data.frame >= base_q) && (rel[19:5] < {4'b0, nc});
		go_scan = (in_data.mode == MODE_ALLOC1) || (in_data.mode == MODE_ALLOC32) ||
			((in_data.mode == MODE_ALLOC8) && (free_now >= FREE_W'(8)));
		go_free = in_rng && (in_data.mode == MODE_FREE1 || in_data.mode == MODE_FREE8 ||
			in_data.mode == MODE_QUERY || (in_data.mode == MODE_FREE32 &&
			(rel[4:3] == 2'd0 || ({1'b0, rel[19:5]} + 16'd1) < {5'b0, nc})));

		p_inc = {1'b0, p_q} + CNT_W'(1);
		p_nx = (p_inc >= n_q) ? '0 : p_inc[WORD_AW-1:0];
		last = (cnt_q + CNT_W'(1)) == n_q;
		skip = ({1'b0, p_q} == (n_q - CNT_W'(1)));

		zb = first_zero_byte(rdata);
		unique case (mode_q)
			MODE_ALLOC1: scan_hit = (rdata != WORD_FULL);
			MODE_ALLOC8: scan_hit = zb[2];
			default: scan_hit = (rdata == '0);
		endcase

		run_sel[0] = run_bits(lo_q, rdata, 2'd1) == '0;
		run_sel[1] = run_bits(lo_q, rdata, 2'd2) == '0;
		run_sel[2] = run_bits(lo_q, rdata, 2'd3) == '0;
		run_hit = |run_sel;
		priority if (run_sel[0]) run_k = 2'd1;
		else if (run_sel[1]) run_k = 2'd2;
		else run_k = 2'd3;

		unique case (mode_q)
			MODE_FREE1: free_ok = rdata[bit_q];
			MODE_FREE8: free_ok = (rdata & byte_mask(k_q)) == byte_mask(k_q);
			MODE_FREE32: free_ok = (k_q == 2'd0) && (rdata == WORD_FULL);
			default: free_ok = 1'b0;
		endcase
		hi_good = run_bits(lo_q, rdata, k_q) == WORD_FULL;
		done_go = !out_valid_q || !out_stall;
	end

	// ---------------- next state ----------------
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			S_CLEAR: if (clr_q == WORD_AW'(MAP_WORDS - 1)) state_d = S_IDLE;
			S_IDLE: if (acc) begin
				if (go_scan) state_d = S_SCAN;
				else if (go_free) state_d = S_FREE_CHK;
				else state_d = S_DONE;
			end
			S_SCAN: begin
				if (scan_hit) state_d = S_DONE;
				else if (last) begin
					state_d = (mode_q == MODE_ALLOC32 && free_q >= FREE_W'(32)) ?
						S_RUN_RD : S_DONE;
				end
			end
			S_RUN_RD: begin
				if (!skip) state_d = S_RUN_LO;
				else if (last) state_d = S_DONE;
			end
			S_RUN_LO: state_d = S_RUN_HI;
			S_RUN_HI: begin
				if (run_hit) state_d = S_RUN_WR2;
				else if (last) state_d = S_DONE;
				else state_d = S_RUN_RD;
			end
			S_RUN_WR2: state_d = S_DONE;
			S_FREE_CHK: state_d = (mode_q == MODE_FREE32 && k_q != 2'd0) ? S_FREE_HI : S_DONE;
			S_FREE_HI: state_d = hi_good ? S_FREE_WR2 : S_DONE;
			S_FREE_WR2: state_d = S_DONE;
			S_DONE: if (done_go) state_d = S_IDLE;
			default: state_d = S_IDLE;
		endcase
	end

	// ---------------- memory controls ----------------
	always_comb begin
		rd_en = 1'b0;
		rd_addr = p_q;
		wr_en = 1'b0;
		wr_addr = p_q;
		wr_data = '0;
		unique case (state_q)
			S_CLEAR: begin
				wr_en = 1'b1;
				wr_addr = clr_q;
			end
			S_IDLE: if (acc) begin
				rd_en = go_scan || go_free;
				rd_addr = go_scan ? start : rel[WORD_AW+4:5];
			end
			S_SCAN: begin
				if (scan_hit) begin
					wr_en = 1'b1;
					unique case (mode_q)
						MODE_ALLOC1: wr_data = rdata | (32'd1 << lowest_zero(rdata));
						MODE_ALLOC8: wr_data = rdata | byte_mask(zb[1:0]);
						default: wr_data = WORD_FULL;
					endcase
				end else if (!last) begin
					rd_en = 1'b1;
					rd_addr = p_nx;
				end
			end
			S_RUN_RD: rd_en = !skip;
			S_RUN_LO: begin
				rd_en = 1'b1;
				rd_addr = p_q + WORD_AW'(1);
			end
			S_RUN_HI: if (run_hit) begin
				wr_en = 1'b1;
				wr_data = lo_q | lo_mask(run_k);
			end
			S_RUN_WR2: begin
				wr_en = 1'b1;
				wr_addr = p_q + WORD_AW'(1);
				wr_data = hi_q | ~lo_mask(k_q);
			end
			S_FREE_CHK: begin
				wr_addr = word_q;
				rd_addr = word_q + WORD_AW'(1);
				if (mode_q == MODE_FREE32 && k_q != 2'd0) rd_en = 1'b1;
				else if (free_ok) begin
					wr_en = 1'b1;
					unique case (mode_q)
						MODE_FREE1: wr_data = rdata & ~(32'd1 << bit_q);
						MODE_FREE8: wr_data = rdata & ~byte_mask(k_q);
						default: wr_data = '0;
					endcase
				end
			end
			S_FREE_HI: begin
				wr_en = hi_good;
				wr_addr = word_q;
				wr_data = lo_q & ~lo_mask(k_q);
			end
			S_FREE_WR2: begin
				wr_en = 1'b1;
				wr_addr = word_q + WORD_AW'(1);
				wr_data = hi_q & lo_mask(k_q);
			end
			S_DONE: ;
			default: ;
		endcase
	end

	// ---------------- registers ----------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_CLEAR;
			clr_q <= '0;
			ptr_q <= '0;
			used_q <= '0;
			aw_q <= ACTIVE_RESET;
			base_q <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cfg_we) begin
				if (cfg_index == REG_ACTIVE_WORDS) aw_q <= cfg_data[CNT_W-1:0];
				else base_q <= cfg_data;
			end
			if (state_q == S_DONE && done_go) out_valid_q <= 1'b1;
			else if (!out_stall) out_valid_q <= 1'b0;
			unique case (state_q)
				S_CLEAR: clr_q <= clr_q + WORD_AW'(1);
				S_IDLE: if (acc && go_scan) ptr_q <= start;
				S_SCAN: if (scan_hit) begin
					ptr_q <= p_q;
					unique case (mode_q)
						MODE_ALLOC1: used_q <= used_q + USED_W'(1);
						MODE_ALLOC8: used_q <= used_q + USED_W'(8);
						default: used_q <= used_q + USED_W'(32);
					endcase
				end
				S_RUN_HI: if (run_hit) begin
					ptr_q <= p_q;
					used_q <= used_q + USED_W'(32);
				end
				S_FREE_CHK: if (free_ok) begin
					unique case (mode_q)
						MODE_FREE1: begin
							used_q <= used_q - USED_W'(1);
							ptr_q <= word_q;
						end
						MODE_FREE8: used_q <= used_q - USED_W'(8);
						default: used_q <= used_q - USED_W'(32);
					endcase
				end
				S_FREE_HI: if (hi_good) used_q <= used_q - USED_W'(32);
				default: ;
			endcase
		end
	end

	// payload and scan bookkeeping
	always_ff @(posedge clk) begin
		unique case (state_q)
			S_IDLE: if (acc) begin
				mode_q <= in_data.mode;
				n_q <= nc;
				free_q <= free_now;
				word_q <= rel[WORD_AW+4:5];
				bit_q <= rel[4:0];
				k_q <= rel[4:3];
				cnt_q <= '0;
				p_q <= start;
				ok_q <= 1'b0;
				isal_q <= 1'b0;
				res_q <= (in_data.mode >= MODE_FREE1) ? in_data.frame : '0;
			end
			S_SCAN: begin
				if (scan_hit) begin
					ok_q <= 1'b1;
					unique case (mode_q)
						MODE_ALLOC1: res_q <= base_q + FRAME_W'({p_q, lowest_zero(rdata)});
						MODE_ALLOC8: res_q <= base_q + FRAME_W'({p_q, zb[1:0], 3'b000});
						default: res_q <= base_q + FRAME_W'({p_q, 5'b00000});
					endcase
				end else begin
					// after the last word the pointer has wrapped back to the start
					p_q <= p_nx;
					cnt_q <= last ? '0 : cnt_q + CNT_W'(1);
				end
			end
			S_RUN_RD: if (skip) begin
				p_q <= p_nx;
				cnt_q <= cnt_q + CNT_W'(1);
			end
			S_RUN_LO: lo_q <= rdata;
			S_RUN_HI: begin
				if (run_hit) begin
					hi_q <= rdata;
					k_q <= run_k;
					ok_q <= 1'b1;
					res_q <= base_q + FRAME_W'({p_q, run_k, 3'b000});
				end else begin
					p_q <= p_nx;
					cnt_q <= cnt_q + CNT_W'(1);
				end
			end
			S_FREE_CHK: begin
				lo_q <= rdata;
				if (mode_q == MODE_QUERY) begin
					isal_q <= rdata[bit_q];
					ok_q <= 1'b1;
				end else if (free_ok) ok_q <= 1'b1;
			end
			S_FREE_HI: if (hi_good) begin
				hi_q <= rdata;
				ok_q <= 1'b1;
			end
			S_DONE: if (done_go) begin
				out_q.result_frame <= res_q;
				out_q.ok <= ok_q;
				out_q.is_allocated <= isal_q;
				out_q.used_count <= used_q;
			end
			default: ;
		endcase
	end

	assign in_stall = (state_q != S_IDLE);
	assign out_valid = out_valid_q;
	assign out_data = out_q;

	// ---------------- checks ----------------
	a_used_bound: assert property (@(posedge clk) disable iff (!arst_n)
		used_q <= USED_W'(MAP_WORDS * 32))
		else $error("used frame count beyond bitmap size");

	a_no_rw_overlap: assert property (@(posedge clk) disable iff (!arst_n)
		!(wr_en && rd_en && wr_addr == rd_addr))
		else $error("read and write of the same word in one cycle");

	a_result_from_done: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(state_q) == S_DONE)
		else $error("result loaded outside the done state");

	a_clear_blocks: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_CLEAR |-> in_stall && !rd_en)
		else $error("request taken during clearing pass");

	a_frees_keep_ptr: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_FREE_HI || state_q == S_FREE_WR2) |=> $stable(ptr_q))
		else $error("pointer moved by a run free");

endmodule

>>> rtl/bpfa_ram.sv
// ----------------------------------------------------------------------------
// bpfa_ram
// Bitmap store: one write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module bpfa_ram
	import bpfa_pkg::*;
(
	input  logic               clk,
	input  logic               wr_en,
	input  logic [WORD_AW-1:0] wr_addr,
	input  logic [31:0]        wr_data,
	input  logic               rd_en,
	input  logic [WORD_AW-1:0] rd_addr,
	output logic [31:0]        rd_data
);

	logic [31:0] mem [MAP_WORDS];

	always_ff @(posedge clk) begin
		if (wr_en) mem[wr_addr] <= wr_data;
	end

	always_ff @(posedge clk) begin
		if (rd_en) rd_data <= mem[rd_addr];
	end

endmodule
